FILE: rtl/lcv_pkg.sv
// Shared constants and types for the lomo curve and vignette pixel block.
package lcv_pkg;

  localparam int MAX_DIM      = 4096;
  localparam int DIM_W        = 13;
  localparam int POS_W        = 12;
  localparam int FADE_W       = 24;
  localparam int MAG_W        = 25;
  localparam int DIV_STEPS    = 16;
  localparam int SETUP_CYCLES = DIV_STEPS + 1;
  localparam int SETUP_CNT_W  = $clog2(SETUP_CYCLES + 1);

  localparam logic [DIM_W-1:0]  WIDTH_RST  = 13'd640;
  localparam logic [DIM_W-1:0]  HEIGHT_RST = 13'd480;
  localparam logic [FADE_W-1:0] FADE_RST   = 24'd31999;

  typedef enum logic [1:0] {
    CFG_IMAGE_WIDTH  = 2'd0,
    CFG_IMAGE_HEIGHT = 2'd1,
    CFG_FADE_START   = 2'd2
  } cfg_idx_t;

  // Frame geometry derived from the configuration registers.
  typedef struct packed {
    logic              gt;       // width above height: scale dx, else dy
    logic [POS_W-1:0]  cx;
    logic [POS_W-1:0]  cy;
    logic [15:0]       ratio;    // Q15 aspect ratio, up to 1.0
    logic [FADE_W-1:0] fade;
    logic              fade_on;  // fade below maxd
    logic [FADE_W-1:0] den;      // maxd - fade
    logic [FADE_W-1:0] maxd;
  } geom_t;

  // Per-pixel data carried alongside the falloff divider.
  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       dark;
  } side_t;

endpackage

FILE: rtl/lomo_curve_vignette_pixel.sv
// Top level: lomo color curves and radial vignette on a stream of ARGB pixels.
// One pixel per cycle while neither setup nor a full skid entry holds intake.
// Five front stages, a 17-stage falloff divider (load plus 16 quotient bits) and three
// back stages, all plain registers; only a full skid entry (output stall) stalls the pipeline.
// After reset and after each configuration write, a setup (serial aspect
// ratio division) holds in_tready low; configuration writes are always taken.
// Reset clears all valid bits, including those of the output register and skid entry.
module lomo_curve_vignette_pixel import lcv_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // input transaction
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // pixel_in[31:0], column[43:32], row[55:44]
  // result transaction
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // pixel_out[31:0]
  // configuration writes
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_wdata
);

  geom_t geom;
  logic  busy;
  logic  en, acc;

  lcv_setup u_setup (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .geom      (geom),
    .busy      (busy)
  );

  // Output register plus one skid entry. The pipeline advances whenever the
  // skid is empty, so a waiting result never blocks intake by itself.
  logic        out_v_r, skid_v_r;
  logic [31:0] out_px_r, skid_px_r;

  assign en        = !skid_v_r;
  assign in_tready = en && !busy;
  assign acc       = in_tvalid && in_tready;

  // stage 1: unpack, fold curve inputs, center offsets
  logic [31:0]       in_px;
  logic [POS_W-1:0]  in_col, in_row;
  logic [7:0]        r0, g0, b0;
  logic [7:0]        rt_c, gt_c, nb_c;
  logic signed [12:0] dx_c, dy_c;

  always_comb begin
    in_px  = in_tdata[31:0];
    in_col = in_tdata[43:32];
    in_row = in_tdata[55:44];
    r0     = in_px[23:16];
    g0     = in_px[15:8];
    b0     = in_px[7:0];
    rt_c   = r0[7] ? 8'(9'd256 - 9'(r0)) : r0;
    gt_c   = g0[7] ? 8'(9'd256 - 9'(g0)) : g0;
    nb_c   = {1'b0, b0[7:1]} + 8'h25;
    dx_c   = $signed({1'b0, geom.cx}) - $signed({1'b0, in_col});
    dy_c   = $signed({1'b0, geom.cy}) - $signed({1'b0, in_row});
  end

  logic               v1_r;
  logic [7:0]         a1_r, rt1_r, gt1_r, nb1_r;
  logic               rhi1_r, ghi1_r;
  logic signed [12:0] dx1_r, dy1_r;

  // stage 2: squares of the folded channels, aspect scaling product
  logic signed [12:0] sel_c, oth_c;
  logic signed [16:0] rat_s;

  always_comb begin
    sel_c = geom.gt ? dx1_r : dy1_r;
    oth_c = geom.gt ? dy1_r : dx1_r;
    rat_s = $signed({1'b0, geom.ratio});
  end

  logic               v2_r;
  logic [7:0]         a2_r, rt2_r, nb2_r;
  logic               rhi2_r, ghi2_r;
  logic [15:0]        rsq2_r, gsq2_r;
  logic signed [29:0] scl2_r;
  logic signed [12:0] oth2_r;

  // stage 3: red cube, green curve, squared offsets (floor by 2^15 is a bit slice)
  logic signed [12:0] sc_c;
  logic signed [25:0] sqa_c, sqo_c;
  logic [7:0]         gq_c, ng_c;

  always_comb begin
    sc_c  = scl2_r[27:15];
    sqa_c = sc_c * sc_c;
    sqo_c = oth2_r * oth2_r;
    gq_c  = gsq2_r[14:7];
    ng_c  = ghi2_r ? 8'd255 - gq_c : gq_c;
  end

  logic        v3_r;
  logic [7:0]  a3_r, ng3_r, nb3_r;
  logic        rhi3_r;
  logic [23:0] rcube3_r, sqa3_r, sqo3_r;

  // stage 4: red curve, squared distance
  logic [7:0] rq_c, nr_c;

  always_comb begin
    rq_c = rcube3_r[21:14];
    nr_c = rhi3_r ? 8'd255 - rq_c : rq_c;
  end

  logic             v4_r;
  logic [7:0]       a4_r, nr4_r, ng4_r, nb4_r;
  logic [MAG_W-1:0] dist4_r;

  // stage 5: darkening decision and |maxd - dist|
  logic signed [MAG_W:0] diff_c;
  logic [MAG_W-1:0]      mag_c;

  always_comb begin
    diff_c = $signed(26'(geom.maxd)) - $signed(26'(dist4_r));
    mag_c  = diff_c[MAG_W] ? MAG_W'(-diff_c) : diff_c[MAG_W-1:0];
  end

  logic             v5_r;
  logic [MAG_W-1:0] mag5_r;
  side_t            side5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (en) begin
      v1_r <= acc;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a1_r   <= in_px[31:24];
      rt1_r  <= rt_c;
      gt1_r  <= gt_c;
      rhi1_r <= r0[7];
      ghi1_r <= g0[7];
      nb1_r  <= nb_c;
      dx1_r  <= dx_c;
      dy1_r  <= dy_c;

      a2_r   <= a1_r;
      rt2_r  <= rt1_r;
      nb2_r  <= nb1_r;
      rhi2_r <= rhi1_r;
      ghi2_r <= ghi1_r;
      rsq2_r <= 16'(rt1_r) * 16'(rt1_r);
      gsq2_r <= 16'(gt1_r) * 16'(gt1_r);
      scl2_r <= sel_c * rat_s;
      oth2_r <= oth_c;

      a3_r     <= a2_r;
      nb3_r    <= nb2_r;
      rhi3_r   <= rhi2_r;
      ng3_r    <= ng_c;
      rcube3_r <= 24'(rsq2_r) * 24'(rt2_r);
      sqa3_r   <= sqa_c[23:0];
      sqo3_r   <= sqo_c[23:0];

      a4_r    <= a3_r;
      nr4_r   <= nr_c;
      ng4_r   <= ng3_r;
      nb4_r   <= nb3_r;
      dist4_r <= MAG_W'(sqa3_r) + MAG_W'(sqo3_r);

      mag5_r        <= mag_c;
      side5_r.alpha <= a4_r;
      side5_r.red   <= nr4_r;
      side5_r.green <= ng4_r;
      side5_r.blue  <= nb4_r;
      side5_r.dark  <= geom.fade_on && (dist4_r > MAG_W'(geom.fade));
    end
  end

  // falloff v = mag * 256 / (maxd - fade), 17 stages
  logic        dv;
  logic [15:0] dq;
  logic        dsat;
  side_t       dside;

  lcv_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v5_r),
    .in_mag    (mag5_r),
    .in_side   (side5_r),
    .den       (geom.den),
    .out_valid (dv),
    .out_quo   (dq),
    .out_sat   (dsat),
    .out_side  (dside)
  );

  // stage 6: v squared; stage 7: channel products; stage 8: clamp and pack
  logic        v6_r, v7_r, v8_r;
  logic [31:0] vsq6_r;
  logic        sat6_r, sat7_r;
  side_t       side6_r, side7_r;
  logic [23:0] pr7_r, pg7_r, pb7_r;
  logic [31:0] px8_r;
  logic [39:0] pr_c, pg_c, pb_c;

  function automatic logic [7:0] shade(logic [7:0] c, logic sat, logic [23:0] p);
    if (c == 8'd0) return 8'd0;
    if (sat) return 8'hFF;
    if (p > 24'd255) return 8'hFF;
    return p[7:0];
  endfunction

  always_comb begin
    pr_c = 40'(side6_r.red) * 40'(vsq6_r);
    pg_c = 40'(side6_r.green) * 40'(vsq6_r);
    pb_c = 40'(side6_r.blue) * 40'(vsq6_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
      v7_r <= 1'b0;
      v8_r <= 1'b0;
    end else if (en) begin
      v6_r <= dv;
      v7_r <= v6_r;
      v8_r <= v7_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vsq6_r  <= 32'(dq) * 32'(dq);
      sat6_r  <= dsat;
      side6_r <= dside;

      pr7_r   <= pr_c[39:16];
      pg7_r   <= pg_c[39:16];
      pb7_r   <= pb_c[39:16];
      sat7_r  <= sat6_r;
      side7_r <= side6_r;

      if (side7_r.dark) begin
        px8_r <= {side7_r.alpha,
                  shade(side7_r.red, sat7_r, pr7_r),
                  shade(side7_r.green, sat7_r, pg7_r),
                  shade(side7_r.blue, sat7_r, pb7_r)};
      end else begin
        px8_r <= {side7_r.alpha, side7_r.red, side7_r.green, side7_r.blue};
      end
    end
  end

  // output register and skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (out_tready) begin
        skid_v_r <= 1'b0;
      end
    end else if (v8_r) begin
      if (!out_v_r || out_tready) begin
        out_v_r <= 1'b1;
      end else begin
        skid_v_r <= 1'b1;
      end
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (out_tready) begin
        out_px_r <= skid_px_r;
      end
    end else if (v8_r) begin
      if (!out_v_r || out_tready) begin
        out_px_r <= px8_r;
      end else begin
        skid_px_r <= px8_r;
      end
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_px_r;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid entry holds data while output register is empty");

  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_v_r) |-> $past(out_v_r && !out_tready))
    else $error("skid filled while output register could take the result");

  a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(skid_v_r) && $past(rst_n) |-> $past(out_tready))
    else $error("skid emptied without an output transaction");

endmodule

FILE: rtl/lcv_setup.sv
// Configuration registers and derived frame geometry with serial ratio divider.
module lcv_setup import lcv_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_wdata,
  output geom_t       geom,
  output logic        busy
);

  logic [DIM_W-1:0]       width_r, height_r;
  logic [FADE_W-1:0]      fade_r;
  logic [SETUP_CNT_W-1:0] cnt_r;

  logic [DIM_W-1:0]  wcl, hcl, dmin, dmax;
  logic              gt_c;
  logic [DIM_W-1:0]  wc_r, hc_r;
  logic              gt_r;
  logic [POS_W-1:0]  cx_r, cy_r;
  logic [22:0]       cx2_r, cy2_r;
  logic [FADE_W-1:0] maxd_r, den_r;
  logic              fade_on_r;

  logic [DIM_W-1:0]  rem_r;
  logic [15:0]       low_r, q_r;
  logic [DIM_W:0]    sh, rem_nxt;
  logic              ge;

  function automatic logic [DIM_W-1:0] clamp_dim(logic [DIM_W-1:0] d);
    if (d == '0) return DIM_W'(1);
    if (d > DIM_W'(MAX_DIM)) return DIM_W'(MAX_DIM);
    return d;
  endfunction

  always_comb begin
    wcl  = clamp_dim(width_r);
    hcl  = clamp_dim(height_r);
    gt_c = wcl > hcl;
    dmin = gt_c ? hcl : wcl;
    dmax = gt_c ? wcl : hcl;
    sh      = {rem_r, low_r[15]};
    ge      = sh >= {1'b0, dmax};
    rem_nxt = ge ? (sh - {1'b0, dmax}) : sh;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
      fade_r   <= FADE_RST;
      cnt_r    <= SETUP_CNT_W'(SETUP_CYCLES);
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_IMAGE_WIDTH:  width_r  <= cfg_wdata[DIM_W-1:0];
        CFG_IMAGE_HEIGHT: height_r <= cfg_wdata[DIM_W-1:0];
        CFG_FADE_START:   fade_r   <= cfg_wdata[FADE_W-1:0];
        default: ;
      endcase
      cnt_r <= SETUP_CNT_W'(SETUP_CYCLES);
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - SETUP_CNT_W'(1);
    end
  end

  // ratio = floor(min * 32768 / max), one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (cnt_r == SETUP_CNT_W'(SETUP_CYCLES)) begin
      rem_r <= {1'b0, dmin[DIM_W-1:1]};
      low_r <= {dmin[0], 15'b0};
      q_r   <= '0;
    end else if (cnt_r != '0) begin
      rem_r <= rem_nxt[DIM_W-1:0];
      low_r <= {low_r[14:0], 1'b0};
      q_r   <= {q_r[14:0], ge};
    end
  end

  // geometry chain settles well inside the setup window
  always_ff @(posedge clk) begin
    wc_r      <= wcl;
    hc_r      <= hcl;
    gt_r      <= wc_r > hc_r;
    cx_r      <= wc_r[DIM_W-1:1];
    cy_r      <= hc_r[DIM_W-1:1];
    cx2_r     <= 23'(cx_r) * 23'(cx_r);
    cy2_r     <= 23'(cy_r) * 23'(cy_r);
    maxd_r    <= 24'(cx2_r) + 24'(cy2_r);
    fade_on_r <= fade_r < maxd_r;
    den_r     <= maxd_r - fade_r;
  end

  assign busy         = cnt_r != '0;
  assign geom.gt      = gt_r;
  assign geom.cx      = cx_r;
  assign geom.cy      = cy_r;
  assign geom.ratio   = q_r;
  assign geom.fade    = fade_r;
  assign geom.fade_on = fade_on_r;
  assign geom.den     = den_r;
  assign geom.maxd    = maxd_r;

  a_write_starts_setup: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> busy)
    else $error("setup did not restart after register write");

  a_ratio_range: assert property (@(posedge clk) disable iff (!rst_n)
    !busy |-> (q_r <= 16'd32768) && (!gt_r || q_r < 16'd32768))
    else $error("aspect ratio out of range after setup");

endmodule

FILE: rtl/lcv_div.sv
// Pipelined restoring divider for the vignette falloff, one quotient bit per stage.
module lcv_div import lcv_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [MAG_W-1:0]  in_mag,
  input  side_t             in_side,
  input  logic [FADE_W-1:0] den,
  output logic              out_valid,
  output logic [15:0]       out_quo,
  output logic              out_sat,
  output side_t             out_side
);

  localparam int NSTG = DIV_STEPS + 1;

  logic [NSTG-1:0]   v_r;
  logic [FADE_W-1:0] rem_r  [NSTG];
  logic [15:0]       low_r  [NSTG];
  logic [15:0]       q_r    [NSTG];
  logic              sat_r  [NSTG];
  side_t             side_r [NSTG];

  logic [FADE_W:0]   sh      [DIV_STEPS];
  logic              ge      [DIV_STEPS];
  logic [FADE_W-1:0] rem_nxt [DIV_STEPS];

  // numerator is mag * 256; quotient above 16 bits saturates
  always_comb begin
    for (int k = 0; k < DIV_STEPS; k++) begin
      sh[k]      = {rem_r[k], low_r[k][15]};
      ge[k]      = sh[k] >= {1'b0, den};
      rem_nxt[k] = ge[k] ? FADE_W'(sh[k] - {1'b0, den}) : sh[k][FADE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NSTG-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= FADE_W'(in_mag[MAG_W-1:8]);
      low_r[0]  <= {in_mag[7:0], 8'b0};
      q_r[0]    <= '0;
      sat_r[0]  <= 32'(in_mag) >= {den, 8'b0};
      side_r[0] <= in_side;
      for (int k = 0; k < DIV_STEPS; k++) begin
        rem_r[k+1]  <= rem_nxt[k];
        low_r[k+1]  <= {low_r[k][14:0], 1'b0};
        q_r[k+1]    <= {q_r[k][14:0], ge[k]};
        sat_r[k+1]  <= sat_r[k];
        side_r[k+1] <= side_r[k];
      end
    end
  end

  assign out_valid = v_r[NSTG-1];
  assign out_quo   = q_r[NSTG-1];
  assign out_sat   = sat_r[NSTG-1];
  assign out_side  = side_r[NSTG-1];

endmodule
